FILE: hw/rtl/fcl_pkg.sv
// ----------------------------------------------------------------------------
// fcl_pkg
// Shared types and constants for the loaded-kernel FIR convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package fcl_pkg;

  // Field widths of one input beat and one result beat
  localparam int unsigned OpW      = 2;
  localparam int unsigned IdxW     = 11;
  localparam int unsigned TapW     = 18;
  localparam int unsigned SmpW     = 16;
  localparam int unsigned ProdW    = TapW + SmpW;
  localparam int unsigned AccW     = 48;
  localparam int unsigned CfgW     = 12;
  localparam int unsigned InDataW  = 48;  // 11 + 18 + 16 = 45, padded to bytes
  localparam int unsigned OutDataW = 48;

  typedef enum logic [OpW-1:0] {
    OP_LOAD   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SAMPLE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  // Sequencer to datapath controls
  typedef struct packed {
    logic tap_we;    // write a kernel tap
    logic hist_we;   // write a sample into the history
    logic issue;     // read one tap / history pair into the MAC
    logic acc_clr;   // start a new sum
    logic out_load;  // move the finished sum to the output register
  } ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fcl_mac.sv
// ----------------------------------------------------------------------------
// fcl_mac
// Shared multiply-accumulate: registered 18x16 product, 48-bit accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module fcl_mac (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               rd_valid_i,
  input  wire logic signed [fcl_pkg::TapW-1:0]    tap_i,
  input  wire logic signed [fcl_pkg::SmpW-1:0]    sample_i,
  input  wire logic                               acc_clr_i,
  output logic                                    busy_o,
  output logic signed [fcl_pkg::AccW-1:0]         acc_o
);

  logic                                  mul_v_q;
  logic signed [fcl_pkg::ProdW-1:0]      mul_q;
  logic signed [fcl_pkg::AccW-1:0]       acc_q, acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
    end else begin
      mul_v_q <= rd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_valid_i) begin
      mul_q <= tap_i * sample_i;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (acc_clr_i) begin
      acc_d = '0;
    end else if (mul_v_q) begin
      acc_d = acc_q + fcl_pkg::AccW'(mul_q);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign busy_o = rd_valid_i | mul_v_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

FILE: hw/rtl/fcl_seq.sv
// ----------------------------------------------------------------------------
// fcl_seq
// Sequencer: decodes beats, keeps history pointer and fill count, and walks
// the taps through the shared MAC.
// ----------------------------------------------------------------------------
`default_nettype none

module fcl_seq #(
  parameter int unsigned MAX_TAPS = 2048,
  parameter int unsigned AW       = 11,
  parameter int unsigned CW       = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire fcl_pkg::op_e                 op_i,
  input  wire logic [fcl_pkg::IdxW-1:0]     tap_index_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [fcl_pkg::CfgW-1:0]     cfg_wdata_i,
  input  wire logic                         mac_busy_i,
  input  wire logic                         out_free_i,
  output fcl_pkg::ctrl_t                    ctrl_o,
  output logic [AW-1:0]                     tap_waddr_o,
  output logic [AW-1:0]                     tap_raddr_o,
  output logic [AW-1:0]                     hist_waddr_o,
  output logic [AW-1:0]                     hist_raddr_o
);

  localparam logic [AW-1:0] LastSlot = AW'(MAX_TAPS - 1);
  localparam logic [CW-1:0] MaxCnt   = CW'(MAX_TAPS);

  fcl_pkg::state_e          state_q, state_d;
  logic [fcl_pkg::CfgW-1:0] tap_count_q;
  logic [AW-1:0]            ptr_q, ptr_d;
  logic [CW-1:0]            fill_q, fill_d;
  logic [AW-1:0]            t_q, t_d;
  logic [AW-1:0]            rd_q, rd_d;
  logic [CW-1:0]            rem_q, rem_d;
  logic [CW-1:0]            cnt_eff;
  logic [CW-1:0]            fill_next;
  logic [CW-1:0]            n_terms;
  logic                     accept;

  assign accept     = in_valid_i & in_ready_o;
  assign in_ready_o = (state_q == fcl_pkg::ST_IDLE);

  // tap count saturates at the store depth
  assign cnt_eff   = (32'(tap_count_q) > MAX_TAPS) ? MaxCnt : CW'(tap_count_q);
  assign fill_next = (fill_q == MaxCnt) ? MaxCnt : fill_q + CW'(1);
  // slots not written since the last clear count as zero, so skip them
  assign n_terms   = (cnt_eff < fill_next) ? cnt_eff : fill_next;

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    fill_d  = fill_q;
    t_d     = t_q;
    rd_d    = rd_q;
    rem_d   = rem_q;
    ctrl_o  = '0;
    case (state_q)
      fcl_pkg::ST_IDLE: begin
        if (accept) begin
          case (op_i)
            fcl_pkg::OP_LOAD: begin
              ctrl_o.tap_we = (32'(tap_index_i) < MAX_TAPS);
            end
            fcl_pkg::OP_CLEAR: begin
              ptr_d  = '0;
              fill_d = '0;
            end
            fcl_pkg::OP_SAMPLE: begin
              ctrl_o.hist_we  = 1'b1;
              ctrl_o.acc_clr  = 1'b1;
              ptr_d   = (ptr_q == LastSlot) ? '0 : ptr_q + AW'(1);
              fill_d  = fill_next;
              t_d     = '0;
              rd_d    = ptr_q;
              rem_d   = n_terms;
              state_d = (n_terms == '0) ? fcl_pkg::ST_DRAIN : fcl_pkg::ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      fcl_pkg::ST_RUN: begin
        ctrl_o.issue = 1'b1;
        t_d   = t_q + AW'(1);
        rd_d  = (rd_q == '0) ? LastSlot : rd_q - AW'(1);
        rem_d = rem_q - CW'(1);
        if (rem_q == CW'(1)) begin
          state_d = fcl_pkg::ST_DRAIN;
        end
      end
      fcl_pkg::ST_DRAIN: begin
        if (!mac_busy_i && out_free_i) begin
          ctrl_o.out_load = 1'b1;
          state_d = fcl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fcl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fcl_pkg::ST_IDLE;
      tap_count_q <= fcl_pkg::CfgW'(1);
      ptr_q       <= '0;
      fill_q      <= '0;
      t_q         <= '0;
      rd_q        <= '0;
      rem_q       <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      fill_q  <= fill_d;
      t_q     <= t_d;
      rd_q    <= rd_d;
      rem_q   <= rem_d;
      if (cfg_we_i) begin
        tap_count_q <= cfg_wdata_i;
      end
    end
  end

  assign tap_waddr_o  = AW'(tap_index_i);
  assign tap_raddr_o  = t_q;
  assign hist_waddr_o = ptr_q;
  assign hist_raddr_o = rd_q;

endmodule

`default_nettype wire

FILE: hw/rtl/fir_convolution_loaded_kernel_top.sv
// ----------------------------------------------------------------------------
// fir_convolution_loaded_kernel_top
// Direct-form FIR convolution of a sample stream with a loaded tap kernel.
// ----------------------------------------------------------------------------
//  Channel   Dir  Bits                     Contents
//  s_axis    in   tuser[1:0]               op (0 load tap, 1 clear, 2 sample)
//                 tdata[47:0]              tap_index, tap_value, sample_value
//  m_axis    out  tdata[47:0]              filtered (signed Q16.32)
//  cfg       in   cfg_wdata_i[11:0]        tap_count, written when cfg_we_i
//
//  A load, clear or ignored beat leaves the input ready for the next beat.
//  A sample beat runs n multiply-accumulates, n = min(tap_count, MAX_TAPS,
//  samples since clear), one per cycle, each reading one tap and one
//  history word; when n is zero the cleared sum goes straight to the output.
//  Reset leaves no clearing pass: a fill count masks unwritten history.
//  A finished sum waits in the output register; the next beat is taken
//  meanwhile, and the following sum stalls only until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_convolution_loaded_kernel_top #(
  parameter int unsigned MAX_TAPS = 2048
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [10:0] tap_index, [28:11] tap_value, [44:29] sample_value, [47:45] zero
  input  wire logic [fcl_pkg::InDataW-1:0]      s_axis_tdata,
  // [1:0] op
  input  wire logic [fcl_pkg::OpW-1:0]          s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [47:0] filtered
  output logic [fcl_pkg::OutDataW-1:0]          m_axis_tdata,
  input  wire logic                             cfg_we_i,
  input  wire logic [fcl_pkg::CfgW-1:0]         cfg_wdata_i
);

  localparam int unsigned AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned CW = $clog2(MAX_TAPS + 1);

  fcl_pkg::ctrl_t                   ctrl;
  logic [AW-1:0]                    tap_waddr, tap_raddr, hist_waddr, hist_raddr;
  logic [fcl_pkg::IdxW-1:0]         in_tap_index;
  logic signed [fcl_pkg::TapW-1:0]  in_tap_value;
  logic signed [fcl_pkg::SmpW-1:0]  in_sample;
  logic signed [fcl_pkg::TapW-1:0]  tap_mem [MAX_TAPS];
  logic signed [fcl_pkg::SmpW-1:0]  hist_mem [MAX_TAPS];
  logic signed [fcl_pkg::TapW-1:0]  tap_rd_q;
  logic signed [fcl_pkg::SmpW-1:0]  hist_rd_q;
  logic                             rd_v_q;
  logic                             mac_busy;
  logic signed [fcl_pkg::AccW-1:0]  acc;
  logic                             out_valid_q;
  logic [fcl_pkg::OutDataW-1:0]     out_data_q;
  logic                             out_free;

  assign in_tap_index = s_axis_tdata[10:0];
  assign in_tap_value = s_axis_tdata[28:11];
  assign in_sample    = s_axis_tdata[44:29];

  assign out_free = !out_valid_q || m_axis_tready;

  fcl_seq #(
    .MAX_TAPS (MAX_TAPS),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (fcl_pkg::op_e'(s_axis_tuser)),
    .tap_index_i  (in_tap_index),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mac_busy_i   (mac_busy),
    .out_free_i   (out_free),
    .ctrl_o       (ctrl),
    .tap_waddr_o  (tap_waddr),
    .tap_raddr_o  (tap_raddr),
    .hist_waddr_o (hist_waddr),
    .hist_raddr_o (hist_raddr)
  );

  // Tap store and sample history: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (ctrl.tap_we) begin
      tap_mem[tap_waddr] <= in_tap_value;
    end
    tap_rd_q <= tap_mem[tap_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.hist_we) begin
      hist_mem[hist_waddr] <= in_sample;
    end
    hist_rd_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= ctrl.issue;
    end
  end

  fcl_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_valid_i (rd_v_q),
    .tap_i      (tap_rd_q),
    .sample_i   (hist_rd_q),
    .acc_clr_i  (ctrl.acc_clr),
    .busy_o     (mac_busy),
    .acc_o      (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_data_q <= fcl_pkg::OutDataW'(acc);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
